// ===== rtl/scv_pkg.sv =====
package scv_pkg;

    // Store geometry.
    localparam int NUM_CHANNELS  = 16;
    localparam int NUM_KERNEL    = 8;
    localparam int SAMPLE_COUNT  = 4;
    localparam int NUM_POSITIONS = 64;
    localparam int NUM_FEATURES  = 1024;

    localparam int CH_W    = $clog2(NUM_CHANNELS);
    localparam int TAP_W   = $clog2(NUM_KERNEL);
    localparam int SMP_W   = $clog2(SAMPLE_COUNT);
    localparam int POS_W   = $clog2(NUM_POSITIONS);
    localparam int FEAT_W  = $clog2(NUM_FEATURES);
    localparam int WADDR_W = CH_W + TAP_W + FEAT_W;
    localparam int AADDR_W = SMP_W + CH_W + POS_W;
    localparam int ACC_DEPTH = SAMPLE_COUNT * NUM_CHANNELS * NUM_POSITIONS;

    // Request codes.
    localparam logic [2:0] REQ_WEIGHT = 3'd0;
    localparam logic [2:0] REQ_BIAS   = 3'd1;
    localparam logic [2:0] REQ_ITEM   = 3'd2;
    localparam logic [2:0] REQ_CLEAR  = 3'd3;
    localparam logic [2:0] REQ_READ   = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_KERNEL   = 3'd0;
    localparam logic [2:0] CFG_STRIDE   = 3'd1;
    localparam logic [2:0] CFG_SHARE    = 3'd2;
    localparam logic [2:0] CFG_BIAS_EN  = 3'd3;
    localparam logic [2:0] CFG_CHANNELS = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic clr_step;
        logic div_step;
        logic mac_step;
        logic rd_finish;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic tap_ok;
        logic ch_last;
        logic nch_zero;
        logic out_zero;
        logic pipe_busy;
    } status_t;

    // Saturate a 33-bit signed sum to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31])
        begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/scv_ctrl.sv =====
module scv_ctrl
    import scv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [2:0] req_type,
    input  status_t    status,
    output cmd_t       cmd,
    output logic       busy
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_MAC,
        ST_DRAIN,
        ST_READ
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // Next state from the current request and datapath status.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_ITEM:  state_next = ST_DIV;
                        REQ_CLEAR: state_next = ST_CLEAR;
                        REQ_READ:  state_next = ST_READ;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (!status.tap_ok ||
                    ((status.ch_last || status.nch_zero) && status.out_zero))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands follow the state.
    always_comb
    begin
        cmd           = '0;
        cmd.accept    = accept;
        cmd.clr_step  = (state_reg == ST_CLEAR);
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.mac_step  = (state_reg == ST_MAC);
        cmd.rd_finish = (state_reg == ST_READ);
    end

    // State register; reset starts the accumulator clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/scv_datapath.sv =====
module scv_datapath
    import scv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output status_t            status,
    input  logic [2:0]         req_type,
    input  logic [1:0]         sample_index,
    input  logic [5:0]         word_position,
    input  logic [9:0]         feature_index,
    input  logic signed [15:0] item_value,
    input  logic [3:0]         channel,
    input  logic [2:0]         tap,
    input  logic signed [15:0] weight_value,
    input  logic [5:0]         out_position,
    input  logic               cfg_valid,
    input  logic [2:0]         cfg_index,
    input  logic [4:0]         cfg_data,
    output logic signed [31:0] read_value,
    output logic               done
);

    // Configuration registers.
    logic [3:0] kernel_reg;
    logic [3:0] stride_reg;
    logic       share_reg;
    logic       bias_en_reg;
    logic [4:0] channels_reg;

    // Bias store and memories.
    logic signed [15:0] bias_reg [NUM_CHANNELS];
    logic signed [15:0] wmem [NUM_CHANNELS * NUM_KERNEL * NUM_FEATURES];
    logic signed [31:0] amem [ACC_DEPTH];

    // Item registers.
    logic [SMP_W-1:0]   smp_reg;
    logic [FEAT_W-1:0]  feat_reg;
    logic signed [15:0] val_reg;
    logic [POS_W-1:0]   q_reg;
    logic [3:0]         rem_reg;
    logic [2:0]         div_cnt_reg;
    logic [6:0]         off_reg;
    logic [CH_W-1:0]    ch_cnt_reg;
    logic [AADDR_W-1:0] clr_addr_reg;

    // Pipeline registers.
    logic                p1_valid_reg;
    logic [AADDR_W-1:0]  p1_addr_reg;
    logic signed [15:0]  w_rd_reg;
    logic signed [31:0]  a_rd_reg;
    logic                p2_valid_reg;
    logic [AADDR_W-1:0]  p2_addr_reg;
    logic signed [31:0]  prod_reg;
    logic signed [31:0]  acc_p2_reg;
    logic signed [15:0]  bias_sel_reg;
    logic signed [31:0]  read_value_reg;
    logic                done_reg;

    logic [3:0]         st_eff;
    logic [3:0]         k_eff;
    logic [4:0]         nch;
    logic [4:0]         div_try;
    logic               div_ge;
    logic [3:0]         rem_next;
    logic [TAP_W-1:0]   row;
    logic               issue;
    logic               rd_accept;
    logic               step_tap;
    logic [WADDR_W-1:0] w_addr;
    logic [AADDR_W-1:0] a_rd_addr;
    logic [AADDR_W-1:0] mac_addr;
    logic signed [31:0] mac_sum;
    logic signed [31:0] rd_sum;

    // Effective configuration.
    assign st_eff = (stride_reg == 4'd0) ? 4'd1 : stride_reg;
    assign k_eff  = (kernel_reg > 4'(NUM_KERNEL)) ? 4'(NUM_KERNEL) : kernel_reg;
    assign nch    = (channels_reg > 5'(NUM_CHANNELS)) ? 5'(NUM_CHANNELS) : channels_reg;

    // One restoring division step of word by stride.
    assign div_try  = {rem_reg, q_reg[POS_W-1]};
    assign div_ge   = (div_try >= {1'b0, st_eff});
    assign rem_next = div_ge ? 4'(div_try - {1'b0, st_eff}) : div_try[3:0];

    // Loop status.
    assign status.clr_last  = &clr_addr_reg;
    assign status.div_last  = (div_cnt_reg == 3'(POS_W - 1));
    assign status.tap_ok    = (off_reg < {3'b0, k_eff});
    assign status.ch_last   = ((5'(ch_cnt_reg) + 5'd1) == nch);
    assign status.nch_zero  = (nch == 5'd0);
    assign status.out_zero  = (q_reg == '0);
    assign status.pipe_busy = p1_valid_reg || p2_valid_reg;

    assign row      = share_reg ? '0 : off_reg[TAP_W-1:0];
    assign issue    = cmd.mac_step && status.tap_ok && !status.nch_zero;
    assign step_tap = cmd.mac_step && status.tap_ok && (status.ch_last || status.nch_zero);
    assign rd_accept = cmd.accept && (req_type == REQ_READ);
    assign w_addr   = {ch_cnt_reg, row, feat_reg};
    assign mac_addr = {smp_reg, ch_cnt_reg, q_reg};
    assign a_rd_addr = rd_accept ? {sample_index, channel, out_position} : mac_addr;

    assign mac_sum = sat32(33'(acc_p2_reg) + 33'(prod_reg));
    assign rd_sum  = sat32(33'(a_rd_reg) + {{9{bias_sel_reg[15]}}, bias_sel_reg, 8'h00});

    assign read_value = read_value_reg;
    assign done       = done_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg   <= 4'd3;
            stride_reg   <= 4'd1;
            share_reg    <= 1'b0;
            bias_en_reg  <= 1'b1;
            channels_reg <= 5'd16;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_KERNEL:   kernel_reg   <= cfg_data[3:0];
                CFG_STRIDE:   stride_reg   <= cfg_data[3:0];
                CFG_SHARE:    share_reg    <= cfg_data[0];
                CFG_BIAS_EN:  bias_en_reg  <= cfg_data[0];
                CFG_CHANNELS: channels_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // Bias store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                bias_reg[i] <= '0;
            end
        end
        else if (cmd.accept && (req_type == REQ_BIAS))
        begin
            bias_reg[channel] <= weight_value;
        end
    end

    // Weight memory: load on request, read for each multiply.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (req_type == REQ_WEIGHT))
        begin
            wmem[{channel, tap, feature_index}] <= weight_value;
        end
        if (issue)
        begin
            w_rd_reg <= wmem[w_addr];
        end
    end

    // Accumulator memory: clearing pass or accumulate write, one read port.
    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            amem[clr_addr_reg] <= '0;
        end
        else if (p2_valid_reg)
        begin
            amem[p2_addr_reg] <= mac_sum;
        end
        if (issue || rd_accept)
        begin
            a_rd_reg <= amem[a_rd_addr];
        end
    end

    // Item capture, division and loop counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg        <= '0;
            rem_reg      <= '0;
            div_cnt_reg  <= '0;
            off_reg      <= '0;
            ch_cnt_reg   <= '0;
            clr_addr_reg <= '0;
        end
        else
        begin
            if (cmd.clr_step)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.accept && (req_type == REQ_ITEM))
            begin
                q_reg       <= word_position;
                rem_reg     <= '0;
                div_cnt_reg <= '0;
                ch_cnt_reg  <= '0;
            end
            else if (cmd.div_step)
            begin
                q_reg       <= {q_reg[POS_W-2:0], div_ge};
                rem_reg     <= rem_next;
                div_cnt_reg <= div_cnt_reg + 1'b1;
                off_reg     <= {3'b0, rem_next};
            end
            else if (step_tap)
            begin
                ch_cnt_reg <= '0;
                if (!status.out_zero)
                begin
                    q_reg   <= q_reg - 1'b1;
                    off_reg <= off_reg + {3'b0, st_eff};
                end
            end
            else if (issue)
            begin
                ch_cnt_reg <= ch_cnt_reg + 1'b1;
            end
        end
    end

    // Payload captured on accept.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            smp_reg      <= sample_index;
            feat_reg     <= feature_index;
            val_reg      <= item_value;
            bias_sel_reg <= bias_en_reg ? bias_reg[channel] : 16'sd0;
        end
    end

    // Multiply-accumulate pipeline control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            done_reg     <= cmd.rd_finish;
        end
    end

    // Pipeline payload and read result.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            p1_addr_reg <= mac_addr;
        end
        if (p1_valid_reg)
        begin
            prod_reg    <= val_reg * w_rd_reg;
            acc_p2_reg  <= a_rd_reg;
            p2_addr_reg <= p1_addr_reg;
        end
        if (cmd.rd_finish)
        begin
            read_value_reg <= rd_sum;
        end
    end

    // Clearing and accumulate writes never share the write port.
    assert property (@(posedge clk) disable iff (!rst_n) !(cmd.clr_step && p2_valid_reg))
        else $error("clear and accumulate write collide");

    // Every issued multiply reaches the write stage, through p1_valid_reg and then p2_valid_reg.
    assert property (@(posedge clk) disable iff (!rst_n) issue |=> ##1 p2_valid_reg)
        else $error("accumulate pipeline lost a word");

    // A read request never overlaps a multiply issue.
    assert property (@(posedge clk) disable iff (!rst_n) !(issue && rd_accept))
        else $error("read port conflict");

    // A result strobe follows a read request, through the read state and then done_reg.
    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> $past(rd_accept, 2))
        else $error("result without read request");

endmodule

// ===== rtl/sparse_conv1d_scatter_accumulate.sv =====
// Sparse 1-D convolution, forward pass, scatter-accumulate form.
// Requests enter on start when busy is low: weight load, bias load, sparse
// item, accumulator clear or read, selected by req_type with the payload
// fields on their own ports. Weight and bias loads complete in the accept
// cycle and leave busy low, so they can be issued every cycle.
// A read drives read_value with done high for exactly one cycle, registered
// through the read state and then done_reg; the receiver cannot stall, and
// the next request may be accepted while that word is shown.
// A sparse item holds busy through word/stride division (one quotient bit per
// cycle), one multiply-accumulate per covered window and channel through the
// single multiply-accumulate unit, a walk that ends at output 0 or at a
// window past the kernel, and then the drain of the pipeline.
// A clear request, and reset, run a clearing pass over the 4096 accumulator
// entries, one per cycle, with busy high until the pass ends.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready. It is to be written only while the block is idle; the
// block itself does not enforce this.
// Reset restores the register defaults and zeroes the bias store; weights
// are undefined until loaded.
module sparse_conv1d_scatter_accumulate
    import scv_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         req_type,
    input  logic [1:0]         sample_index,
    input  logic [5:0]         word_position,
    input  logic [9:0]         feature_index,
    input  logic signed [15:0] item_value,
    input  logic [3:0]         channel,
    input  logic [2:0]         tap,
    input  logic signed [15:0] weight_value,
    input  logic [5:0]         out_position,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [4:0]         cfg_data,
    output logic signed [31:0] read_value,
    output logic               done
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    // Sequencer.
    scv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    // Stores, divider and multiply-accumulate pipeline.
    scv_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .req_type      (req_type),
        .sample_index  (sample_index),
        .word_position (word_position),
        .feature_index (feature_index),
        .item_value    (item_value),
        .channel       (channel),
        .tap           (tap),
        .weight_value  (weight_value),
        .out_position  (out_position),
        .cfg_valid     (cfg_valid && cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .read_value    (read_value),
        .done          (done)
    );

endmodule

// ===== verif/sparse_conv1d_scatter_accumulate_tb.sv =====
module sparse_conv1d_scatter_accumulate_tb;
    import scv_pkg::*;

    localparam int  RANDOM_WORDS = 540;
    localparam int  CYCLE_LIMIT  = 20000000;
    localparam int  NUM_FEAT_SET = 3;
    localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;
    localparam logic [2:0] CFG_SPARE       = 3'd7;

    typedef struct {
        logic [2:0]         rtype;
        logic [1:0]         smp;
        logic [5:0]         word;
        logic [9:0]         feat;
        logic signed [15:0] ival;
        logic [3:0]         ch;
        logic [2:0]         tp;
        logic signed [15:0] wval;
        logic [5:0]         opos;
    } req_t;

    typedef struct {
        req_t               r;
        bit                 known;
        logic signed [31:0] value;
    } row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         req_type = '0;
    logic [1:0]         sample_index = '0;
    logic [5:0]         word_position = '0;
    logic [9:0]         feature_index = '0;
    logic signed [15:0] item_value = '0;
    logic [3:0]         channel = '0;
    logic [2:0]         tap = '0;
    logic signed [15:0] weight_value = '0;
    logic [5:0]         out_position = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [4:0]         cfg_data = '0;
    logic signed [31:0] read_value;
    logic               done;

    sparse_conv1d_scatter_accumulate dut (.*);

    // Clock with a 10-unit period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the block's registers and stores.
    logic [3:0]         kernel_reg;
    logic [3:0]         stride_reg;
    logic               share_reg;
    logic               bias_en_reg;
    logic [4:0]         chan_reg;
    logic signed [15:0] weight_mem [0:NUM_CHANNELS*NUM_KERNEL*NUM_FEATURES-1];
    logic signed [15:0] bias_mem [0:NUM_CHANNELS-1];
    logic signed [31:0] acc_mem [0:ACC_DEPTH-1];

    logic signed [31:0] read_q [$];
    logic [9:0]         feat_set [NUM_FEAT_SET];
    int                 errors = 0;
    int                 reads_seen = 0;
    int                 items_sent = 0;
    int                 cycles = 0;
    int                 gap_pct = 0;

    function automatic longint clip32(input longint v);
        longint r;
        r = v;
        if (v > 64'sd2147483647)
        begin
            r = 64'sd2147483647;
        end
        else if (v < -64'sd2147483648)
        begin
            r = -64'sd2147483648;
        end
        return r;
    endfunction

    // Scatter one sparse word into every window that covers it.
    function automatic void scatter_word(input req_t r);
        int     k;
        int     st;
        int     nch;
        int     off;
        int     row;
        int     a;
        longint sum;
        k   = (kernel_reg > NUM_KERNEL) ? NUM_KERNEL : kernel_reg;
        st  = (stride_reg == 0) ? 1 : stride_reg;
        nch = (chan_reg > NUM_CHANNELS) ? NUM_CHANNELS : chan_reg;
        for (int o = r.word / st; o >= 0; o--)
        begin
            off = r.word - o * st;
            if (off >= k)
            begin
                break;
            end
            row = share_reg ? 0 : off;
            for (int c = 0; c < nch; c++)
            begin
                a = (r.smp * NUM_CHANNELS + c) * NUM_POSITIONS + o;
                sum = longint'(acc_mem[a]) + longint'(r.ival) *
                      longint'(weight_mem[(c * NUM_KERNEL + row) * NUM_FEATURES + r.feat]);
                acc_mem[a] = 32'(clip32(sum));
            end
        end
    endfunction

    // Apply one accepted word to the shadow state; returns 1 when a read.
    function automatic bit conv_predict(input req_t r, output logic signed [31:0] v);
        longint s;
        v = '0;
        case (r.rtype)
            REQ_WEIGHT: weight_mem[(r.ch * NUM_KERNEL + r.tp) * NUM_FEATURES + r.feat] = r.wval;
            REQ_BIAS:   bias_mem[r.ch] = r.wval;
            REQ_ITEM:   scatter_word(r);
            REQ_CLEAR:
            begin
                foreach (acc_mem[i])
                begin
                    acc_mem[i] = '0;
                end
            end
            REQ_READ:
            begin
                s = acc_mem[(r.smp * NUM_CHANNELS + r.ch) * NUM_POSITIONS + r.opos];
                if (bias_en_reg)
                begin
                    s = clip32(s + longint'(bias_mem[r.ch]) * 256);
                end
                v = 32'(s);
                return 1'b1;
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic req_t mk(input logic [2:0] t, input int smp, input int word,
                                input int feat, input int ival, input int ch,
                                input int tp, input int wval, input int opos);
        req_t r;
        r.rtype = t;
        r.smp   = 2'(smp);
        r.word  = 6'(word);
        r.feat  = 10'(feat);
        r.ival  = 16'(ival);
        r.ch    = 4'(ch);
        r.tp    = 3'(tp);
        r.wval  = 16'(wval);
        r.opos  = 6'(opos);
        return r;
    endfunction

    // Send one word and update the prediction when it is accepted.
    task automatic send_word(input req_t r, output logic signed [31:0] v, output bit is_read);
        if (($urandom % 100) < gap_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
        @(negedge clk);
        start         <= 1'b1;
        req_type      <= r.rtype;
        sample_index  <= r.smp;
        word_position <= r.word;
        feature_index <= r.feat;
        item_value    <= r.ival;
        channel       <= r.ch;
        tap           <= r.tp;
        weight_value  <= r.wval;
        out_position  <= r.opos;
        forever
        begin
            @(posedge clk);
            if (!busy)
            begin
                break;
            end
        end
        is_read = conv_predict(r, v);
        if (is_read)
        begin
            read_q.push_back(v);
        end
        items_sent++;
    endtask

    // Wait until nothing is outstanding and the block has gone quiet.
    task automatic drain_block();
        @(negedge clk);
        start <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (read_q.size() == 0 && !busy)
            begin
                break;
            end
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [4:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
            begin
                break;
            end
        end
        case (idx)
            CFG_KERNEL:   kernel_reg  = data[3:0];
            CFG_STRIDE:   stride_reg  = data[3:0];
            CFG_SHARE:    share_reg   = data[0];
            CFG_BIAS_EN:  bias_en_reg = data[0];
            CFG_CHANNELS: chan_reg    = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input int k, input int st, input int sh, input int be,
                              input int nch);
        drain_block();
        write_reg(CFG_KERNEL, 5'(k));
        write_reg(CFG_STRIDE, 5'(st));
        write_reg(CFG_SHARE, 5'(sh));
        write_reg(CFG_BIAS_EN, 5'(be));
        write_reg(CFG_CHANNELS, 5'(nch));
    endtask

    function automatic req_t random_word();
        req_t r;
        int   sel;
        r = mk(REQ_ITEM, $urandom_range(0, 3), $urandom_range(0, 63),
               feat_set[$urandom_range(0, NUM_FEAT_SET - 1)],
               ($urandom % 2) ? $urandom : $urandom_range(0, 1023) - 512,
               $urandom_range(0, 15), $urandom_range(0, 7),
               ($urandom % 2) ? $urandom : $urandom_range(0, 1023) - 512,
               $urandom_range(0, 63));
        sel = $urandom % 100;
        if (sel < 18)
        begin
            r.rtype = REQ_WEIGHT;
            // Loads to features outside the working set are never read back.
            if ($urandom % 4 == 0)
            begin
                r.feat = 10'($urandom);
            end
        end
        else if (sel < 24)
        begin
            r.rtype = REQ_BIAS;
        end
        else if (sel < 25)
        begin
            r.rtype = REQ_CLEAR;
        end
        else if (sel < 28)
        begin
            r.rtype = 3'($urandom_range(REQ_SPARE_FIRST, REQ_SPARE_LAST));
        end
        else if (sel < 62)
        begin
            r.rtype = REQ_READ;
            // Reads mostly land near recent activity at low positions.
            if ($urandom % 2)
            begin
                r.opos = 6'($urandom_range(0, 9));
            end
        end
        return r;
    endfunction

    // Check every read result against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            reads_seen++;
            if (read_q.size() == 0)
            begin
                $display("%0t: read_value %0d with no read outstanding", $time, read_value);
                errors++;
            end
            else if (read_value !== read_q[0])
            begin
                $display("%0t: read_value expected %0d actual %0d", $time, read_q[0],
                         read_value);
                errors++;
                void'(read_q.pop_front());
            end
            else
            begin
                void'(read_q.pop_front());
            end
        end
    end

    // Give up if the run hangs.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        row_t               rows [$];
        logic signed [31:0] v;
        bit                 is_read;
        int                 phase_words;

        kernel_reg  = 4'd3;
        stride_reg  = 4'd1;
        share_reg   = 1'b0;
        bias_en_reg = 1'b1;
        chan_reg    = 5'd16;
        foreach (bias_mem[i])
        begin
            bias_mem[i] = '0;
        end
        foreach (acc_mem[i])
        begin
            acc_mem[i] = '0;
        end
        feat_set[0] = 10'd0;
        feat_set[1] = 10'h3FF;
        feat_set[2] = 10'd1;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed words; expected values given where they are obvious.
        rows.push_back('{mk(REQ_READ, 3, 0, 0, 0, 15, 0, 0, 63), 1'b1, 32'sd0});
        rows.push_back('{mk(REQ_BIAS, 0, 0, 0, 0, 3, 0, 32767, 0), 1'b0, 0});
        rows.push_back('{mk(REQ_READ, 2, 0, 0, 0, 3, 0, 0, 5), 1'b1, 32'sh007F_FF00});
        rows.push_back('{mk(REQ_BIAS, 0, 0, 0, 0, 4, 0, -32768, 0), 1'b0, 0});
        rows.push_back('{mk(REQ_READ, 0, 0, 0, 0, 4, 0, 0, 0), 1'b1, 32'shFF80_0000});
        rows.push_back('{mk(REQ_SPARE_FIRST, 1, 7, 1, 99, 2, 2, 99, 7), 1'b0, 0});
        rows.push_back('{mk(3'd6, 2, 8, 2, 99, 2, 2, 99, 7), 1'b0, 0});
        rows.push_back('{mk(REQ_SPARE_LAST, 3, 9, 4, 99, 2, 2, 99, 7), 1'b0, 0});
        // Positive saturation at word 0 through tap row 0 of channel 0.
        rows.push_back('{mk(REQ_WEIGHT, 0, 0, 1, 0, 0, 0, -32768, 0), 1'b0, 0});
        for (int i = 0; i < 3; i++)
        begin
            rows.push_back('{mk(REQ_ITEM, 0, 0, 1, -32768, 0, 0, 0, 0), 1'b0, 0});
        end
        rows.push_back('{mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 32'sh7FFF_FFFF});
        // Negative saturation in sample 1.
        for (int i = 0; i < 3; i++)
        begin
            rows.push_back('{mk(REQ_ITEM, 1, 0, 1, 32767, 0, 0, 0, 0), 1'b0, 0});
        end
        rows.push_back('{mk(REQ_READ, 1, 0, 0, 0, 0, 0, 0, 0), 1'b1, 32'sh8000_0000});
        // Bias pushes a saturated accumulator no further.
        rows.push_back('{mk(REQ_BIAS, 0, 0, 0, 0, 0, 0, 32767, 0), 1'b0, 0});
        rows.push_back('{mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, 32'sh7FFF_FFFF});
        rows.push_back('{mk(REQ_ITEM, 3, 63, 10'h3FF, 32767, 0, 0, 0, 0), 1'b0, 0});
        rows.push_back('{mk(REQ_READ, 3, 0, 0, 0, 15, 0, 0, 62), 1'b0, 0});
        rows.push_back('{mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, 0});
        rows.push_back('{mk(REQ_READ, 1, 0, 0, 0, 0, 0, 0, 0), 1'b1, 32'sh007F_FF00});

        // Load every channel and tap for the working set of features.
        for (int f = 0; f < NUM_FEAT_SET; f++)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                for (int t = 0; t < NUM_KERNEL; t++)
                begin
                    send_word(mk(REQ_WEIGHT, 0, 0, feat_set[f], 0, c, t,
                                 $urandom_range(0, 511) - 256, 0), v, is_read);
                end
            end
        end

        // Rows with a typed value check the block's word against that value.
        foreach (rows[i])
        begin
            send_word(rows[i].r, v, is_read);
            if (rows[i].known)
            begin
                if (v !== rows[i].value)
                begin
                    $display("%0t: directed row %0d expected %0d predicted %0d", $time, i,
                             rows[i].value, v);
                    errors++;
                end
                if (is_read)
                begin
                    read_q[read_q.size() - 1] = rows[i].value;
                end
            end
        end

        // Random traffic over a range of settings, extremes included.
        phase_words = RANDOM_WORDS / 10;
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: set_config(1, 1, 0, 0, 1);
                1: set_config(8, 8, 1, 1, 16);
                2: set_config(15, 0, 0, 1, 31);
                3: set_config(0, 3, 1, 0, 0);
                4: set_config(19, 2, 0, 1, 7);
                5: set_config(5, 15, 0, 1, 16);
                6:
                begin
                    set_config(3, 1, 0, 1, 16);
                    write_reg(CFG_SPARE, 5'h1F);
                end
                default: set_config($urandom_range(1, 8), $urandom_range(1, 8),
                                    $urandom_range(0, 1), $urandom_range(0, 1),
                                    $urandom_range(1, 16));
            endcase
            gap_pct = (ph < 3) ? 17 : (ph < 6) ? 84 : 0;
            for (int i = 0; i < phase_words; i++)
            begin
                send_word(random_word(), v, is_read);
            end
        end

        drain_block();
        repeat (20) @(posedge clk);
        $display("sent %0d words over 10 register settings, checked %0d reads", items_sent,
                 reads_seen);
        $display("%0d mismatches, %0d reads still outstanding", errors, read_q.size());
        if (errors == 0 && read_q.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/scv_pkg.sv
rtl/scv_ctrl.sv
rtl/scv_datapath.sv
rtl/sparse_conv1d_scatter_accumulate.sv
verif/sparse_conv1d_scatter_accumulate_tb.sv
